// ===== rtl/i2crm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crm_pkg
// Shared types and constants of the I2C register master: sequencer steps,
// byte roles, configuration indexes and the item structs of both channels.
// ----------------------------------------------------------------------------
package i2crm_pkg;

    // sizing
    localparam int MAX_BURST         = 256;
    localparam int TICK_COUNTER_BITS = 10;
    localparam int PHASE_W           = 10;
    localparam int PREAMBLE_W        = 5;
    localparam int COUNT_W           = 9;

    // configuration reset values
    localparam logic [PHASE_W-1:0]    PHASE_TICKS_RESET = 10'd1;
    localparam logic [PREAMBLE_W-1:0] PREAMBLE_RESET    = 5'd16;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_PHASE_TICKS     = 1'b0,
        CFG_PREAMBLE_PULSES = 1'b1
    } cfg_index_t;

    // sequencer steps
    typedef enum logic [4:0] {
        ST_IDLE      = 5'd0,
        ST_PRE_HI    = 5'd1,
        ST_PRE_LO    = 5'd2,
        ST_STA_A     = 5'd3,
        ST_STA_B     = 5'd4,
        ST_STA_C     = 5'd5,
        ST_STA_D     = 5'd6,
        ST_TX_LO     = 5'd7,
        ST_TX_SET    = 5'd8,
        ST_TX_HI     = 5'd9,
        ST_ACK_LO    = 5'd10,
        ST_ACK_HI    = 5'd11,
        ST_WAIT_DATA = 5'd12,
        ST_RX_LO     = 5'd13,
        ST_RX_HI     = 5'd14,
        ST_MACK_LO   = 5'd15,
        ST_MACK_SET  = 5'd16,
        ST_MACK_HI   = 5'd17,
        ST_STOP_A    = 5'd18,
        ST_STOP_B    = 5'd19,
        ST_STOP_C    = 5'd20,
        ST_STOP_D    = 5'd21
    } step_t;

    // which byte is on the bus
    typedef enum logic [2:0] {
        ROLE_ADDR_W = 3'd0,
        ROLE_REG_HI = 3'd1,
        ROLE_REG_LO = 3'd2,
        ROLE_DATA   = 3'd3,
        ROLE_ADDR_R = 3'd4,
        ROLE_RX     = 3'd5
    } role_t;

    // one input tick
    typedef struct packed {
        logic               command_valid;
        logic               mode;
        logic [6:0]         device_address;
        logic [15:0]        register_address;
        logic [COUNT_W-1:0] byte_count;
        logic [7:0]         write_byte;
        logic               write_byte_valid;
        logic               sda_sample;
    } in_t;

    // one result tick
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive_enable;
        logic [7:0] read_byte;
        logic       read_byte_valid;
        logic       read_last;
        logic       write_byte_taken;
        logic       nack_seen;
        logic       busy_res;
        logic       done_res;
    } out_t;

    // sequencer state apart from the tick counter
    typedef struct packed {
        step_t                 step;
        role_t                 role;
        logic [2:0]            bit_cnt;
        logic [COUNT_W-1:0]    bytes_left;
        logic [7:0]            shift_byte;
        logic [PREAMBLE_W-1:0] pulse_cnt;
        logic [6:0]            dev_addr;
        logic [15:0]           reg_addr;
        logic                  rd_mode;
        logic                  nack;
        logic                  scl;
        logic                  sda;
        logic                  sda_oe;
    } seq_state_t;

endpackage

// ===== rtl/i2crm_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2crm_step
// Combinational sequencer update for one tick: from the current state, the
// tick counter, the configuration and one input item to the next state and
// the result item of that tick.
// ----------------------------------------------------------------------------
module i2crm_step #(
    parameter int TICK_BITS = i2crm_pkg::TICK_COUNTER_BITS
) (
    input  i2crm_pkg::seq_state_t                    cur,
    input  logic [TICK_BITS-1:0]                     tick_cur,
    input  logic [i2crm_pkg::PHASE_W-1:0]            phase_ticks,
    input  logic [i2crm_pkg::PREAMBLE_W-1:0]         preamble_pulses,
    input  i2crm_pkg::in_t                           item,
    output i2crm_pkg::seq_state_t                    nxt,
    output logic [TICK_BITS-1:0]                     tick_nxt,
    output i2crm_pkg::out_t                          res
);
    import i2crm_pkg::*;

    step_t                 step_next;
    step_t                 take_step;
    logic                  tick_zero;
    logic                  do_adv;
    logic                  entered;
    logic [PREAMBLE_W-1:0] pulse_inc;
    logic [2:0]            bit_inc;
    logic [COUNT_W-1:0]    bytes_dec;
    logic                  bytes_dec_zero;
    logic [TICK_BITS-1:0]  phase_cut;
    logic [TICK_BITS-1:0]  tick_reload;

    // shared helper terms
    assign tick_zero      = (tick_cur == '0);
    assign do_adv         = (cur.step != ST_IDLE) && (cur.step != ST_WAIT_DATA) && tick_zero;
    assign pulse_inc      = cur.pulse_cnt + PREAMBLE_W'(1);
    assign bit_inc        = cur.bit_cnt + 3'd1;
    assign bytes_dec      = (cur.bytes_left != '0) ? cur.bytes_left - COUNT_W'(1)
                                                   : cur.bytes_left;
    assign bytes_dec_zero = (bytes_dec == '0);
    assign take_step      = item.write_byte_valid ? ST_TX_LO : ST_WAIT_DATA;
    assign phase_cut      = TICK_BITS'(phase_ticks);
    assign tick_reload    = (phase_cut == '0) ? '0 : phase_cut - TICK_BITS'(1);

    // next step
    always_comb
    begin
        step_next = cur.step;
        if (cur.step == ST_IDLE)
        begin
            if (item.command_valid)
            begin
                step_next = (preamble_pulses != '0) ? ST_PRE_HI : ST_STA_A;
            end
        end
        else if (cur.step == ST_WAIT_DATA)
        begin
            step_next = take_step;
        end
        else if (do_adv)
        begin
            unique case (cur.step)
                ST_PRE_HI:   step_next = ST_PRE_LO;
                ST_PRE_LO:   step_next = (pulse_inc < preamble_pulses) ? ST_PRE_HI : ST_STA_A;
                ST_STA_A:    step_next = ST_STA_B;
                ST_STA_B:    step_next = ST_STA_C;
                ST_STA_C:    step_next = ST_STA_D;
                ST_STA_D:    step_next = ST_TX_LO;
                ST_TX_LO:    step_next = ST_TX_SET;
                ST_TX_SET:   step_next = ST_TX_HI;
                ST_TX_HI:    step_next = (bit_inc == 3'd0) ? ST_ACK_LO : ST_TX_LO;
                ST_ACK_LO:   step_next = ST_ACK_HI;
                ST_ACK_HI:
                begin
                    unique case (cur.role)
                        ROLE_ADDR_W: step_next = ST_TX_LO;
                        ROLE_REG_HI: step_next = ST_TX_LO;
                        ROLE_REG_LO: step_next = cur.rd_mode ? ST_STA_A : take_step;
                        ROLE_DATA:   step_next = bytes_dec_zero ? ST_STOP_A : take_step;
                        ROLE_ADDR_R: step_next = ST_RX_LO;
                        default:     step_next = ST_STOP_A;
                    endcase
                end
                ST_RX_LO:    step_next = ST_RX_HI;
                ST_RX_HI:    step_next = (bit_inc == 3'd0) ? ST_MACK_LO : ST_RX_LO;
                ST_MACK_LO:  step_next = ST_MACK_SET;
                ST_MACK_SET: step_next = ST_MACK_HI;
                ST_MACK_HI:  step_next = (cur.bytes_left == '0) ? ST_STOP_A : ST_RX_LO;
                ST_STOP_A:   step_next = ST_STOP_B;
                ST_STOP_B:   step_next = ST_STOP_C;
                ST_STOP_C:   step_next = ST_STOP_D;
                default:     step_next = ST_IDLE;
            endcase
        end
    end

    // a pin phase starts on every move into a timed step
    assign entered = (step_next != cur.step) && (step_next != ST_IDLE)
                     && (step_next != ST_WAIT_DATA);

    // datapath, pin levels and result
    always_comb
    begin
        logic [COUNT_W-1:0] n_cnt;
        logic [7:0]         rx_byte;

        n_cnt   = item.byte_count;
        rx_byte = {cur.shift_byte[6:0], item.sda_sample};
        nxt      = cur;
        nxt.step = step_next;
        res      = '0;

        if (n_cnt == '0)
        begin
            n_cnt = COUNT_W'(1);
        end
        if (32'(n_cnt) > 32'(MAX_BURST))
        begin
            n_cnt = COUNT_W'(MAX_BURST);
        end

        // command latch
        if ((cur.step == ST_IDLE) && item.command_valid)
        begin
            nxt.rd_mode    = item.mode;
            nxt.dev_addr   = item.device_address;
            nxt.reg_addr   = item.register_address;
            nxt.bytes_left = n_cnt;
            nxt.nack       = 1'b0;
            nxt.pulse_cnt  = '0;
            nxt.bit_cnt    = 3'd0;
            nxt.role       = ROLE_ADDR_W;
            nxt.shift_byte = {item.device_address, 1'b0};
        end

        // write data handshake while parked
        if ((cur.step == ST_WAIT_DATA) && item.write_byte_valid)
        begin
            res.write_byte_taken = 1'b1;
            nxt.shift_byte       = item.write_byte;
            nxt.bit_cnt          = 3'd0;
        end

        // end-of-phase actions
        if (do_adv)
        begin
            unique case (cur.step)
                ST_PRE_LO: nxt.pulse_cnt = pulse_inc;
                ST_STA_D:  nxt.bit_cnt = 3'd0;
                ST_TX_HI:
                begin
                    nxt.shift_byte = {cur.shift_byte[6:0], 1'b0};
                    nxt.bit_cnt    = bit_inc;
                end
                ST_ACK_HI:
                begin
                    if (item.sda_sample)
                    begin
                        nxt.nack = 1'b1;
                    end
                    unique case (cur.role)
                        ROLE_ADDR_W:
                        begin
                            nxt.role       = ROLE_REG_HI;
                            nxt.shift_byte = cur.reg_addr[15:8];
                            nxt.bit_cnt    = 3'd0;
                        end
                        ROLE_REG_HI:
                        begin
                            nxt.role       = ROLE_REG_LO;
                            nxt.shift_byte = cur.reg_addr[7:0];
                            nxt.bit_cnt    = 3'd0;
                        end
                        ROLE_REG_LO:
                        begin
                            if (cur.rd_mode)
                            begin
                                nxt.role       = ROLE_ADDR_R;
                                nxt.shift_byte = {cur.dev_addr, 1'b1};
                            end
                            else
                            begin
                                nxt.role = ROLE_DATA;
                                if (item.write_byte_valid)
                                begin
                                    res.write_byte_taken = 1'b1;
                                    nxt.shift_byte       = item.write_byte;
                                    nxt.bit_cnt          = 3'd0;
                                end
                            end
                        end
                        ROLE_DATA:
                        begin
                            nxt.bytes_left = bytes_dec;
                            if (!bytes_dec_zero && item.write_byte_valid)
                            begin
                                res.write_byte_taken = 1'b1;
                                nxt.shift_byte       = item.write_byte;
                                nxt.bit_cnt          = 3'd0;
                            end
                        end
                        ROLE_ADDR_R:
                        begin
                            nxt.role       = ROLE_RX;
                            nxt.shift_byte = 8'd0;
                            nxt.bit_cnt    = 3'd0;
                        end
                        default:
                        begin
                            nxt.role = cur.role;
                        end
                    endcase
                end
                ST_RX_HI:
                begin
                    nxt.shift_byte = rx_byte;
                    nxt.bit_cnt    = bit_inc;
                    if (bit_inc == 3'd0)
                    begin
                        nxt.bytes_left      = bytes_dec;
                        res.read_byte_valid = 1'b1;
                        res.read_byte       = rx_byte;
                        res.read_last       = bytes_dec_zero;
                    end
                end
                ST_MACK_HI:
                begin
                    if (cur.bytes_left != '0)
                    begin
                        nxt.shift_byte = 8'd0;
                    end
                end
                ST_STOP_D: res.done_res = 1'b1;
                default:   nxt.bit_cnt = cur.bit_cnt;
            endcase
        end

        // pin levels of the step being entered
        if (entered)
        begin
            unique case (step_next)
                ST_PRE_HI, ST_STA_C, ST_TX_HI, ST_ACK_HI, ST_RX_HI, ST_MACK_HI, ST_STOP_C:
                begin
                    nxt.scl = 1'b1;
                end
                ST_PRE_LO, ST_STA_A, ST_TX_LO, ST_MACK_LO, ST_STOP_A:
                begin
                    nxt.scl = 1'b0;
                end
                ST_ACK_LO, ST_RX_LO:
                begin
                    nxt.scl    = 1'b0;
                    nxt.sda_oe = 1'b0;
                end
                ST_STA_B, ST_STOP_D:
                begin
                    nxt.sda    = 1'b1;
                    nxt.sda_oe = 1'b1;
                end
                ST_STA_D, ST_STOP_B:
                begin
                    nxt.sda    = 1'b0;
                    nxt.sda_oe = 1'b1;
                end
                ST_TX_SET:
                begin
                    nxt.sda    = cur.shift_byte[7];
                    nxt.sda_oe = 1'b1;
                end
                ST_MACK_SET:
                begin
                    nxt.sda    = (cur.bytes_left == '0);
                    nxt.sda_oe = 1'b1;
                end
                default:
                begin
                    nxt.scl = cur.scl;
                end
            endcase
        end

        // phase hold counter
        if (entered)
        begin
            tick_nxt = tick_reload;
        end
        else if (do_adv)
        begin
            tick_nxt = '0;
        end
        else if ((cur.step != ST_IDLE) && (cur.step != ST_WAIT_DATA))
        begin
            tick_nxt = tick_cur - TICK_BITS'(1);
        end
        else
        begin
            tick_nxt = tick_cur;
        end

        res.scl_level        = nxt.scl;
        res.sda_level        = nxt.sda;
        res.sda_drive_enable = nxt.sda_oe;
        res.nack_seen        = nxt.nack;
        res.busy_res         = (step_next != ST_IDLE);
    end

endmodule

// ===== rtl/i2c_register_master_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_master_core
// Bit-level I2C master for devices with 16-bit register addresses: bus-clear
// preamble, START, address and register bytes, burst write or burst read
// with repeated START, STOP.
// ----------------------------------------------------------------------------
// Every transaction on the input channel is one timing tick carrying the SDA
// sample and command fields; every tick yields exactly one result
// transaction with the SCL/SDA levels and byte/status flags. A tick passes
// an input register and then a result register before its result is
// offered, and one tick is taken every cycle when the output side does not
// stall; the combinational sequencer update between those two registers
// sets that rate. Write configuration only while the bus is idle.
module i2c_register_master_core #(
    parameter int TICK_COUNTER_BITS = i2crm_pkg::TICK_COUNTER_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  i2crm_pkg::in_t                    in_item,
    output logic                              out_valid,
    input  logic                              out_stall,
    output i2crm_pkg::out_t                   out_item,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  i2crm_pkg::cfg_index_t             cfg_index,
    input  logic [i2crm_pkg::PHASE_W-1:0]     cfg_data
);
    import i2crm_pkg::*;

    logic                         in_valid_reg;
    in_t                          in_item_reg;
    logic                         out_valid_reg;
    out_t                         out_item_reg;
    seq_state_t                   state_reg;
    seq_state_t                   state_next;
    logic [TICK_COUNTER_BITS-1:0] tick_reg;
    logic [TICK_COUNTER_BITS-1:0] tick_next;
    out_t                         res_next;
    logic [PHASE_W-1:0]           phase_reg;
    logic [PREAMBLE_W-1:0]        preamble_reg;
    logic                         pipe_en;
    logic                         proc_en;

    // pipeline control
    assign pipe_en   = !out_valid_reg || !out_stall;
    assign proc_en   = pipe_en && in_valid_reg;
    assign in_stall  = in_valid_reg && !pipe_en;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PHASE_TICKS_RESET;
            preamble_reg <= PREAMBLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PHASE_TICKS:     phase_reg    <= cfg_data;
                CFG_PREAMBLE_PULSES: preamble_reg <= cfg_data[PREAMBLE_W-1:0];
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_item_reg <= in_item;
        end
    end

    // sequencer update
    i2crm_step #(
        .TICK_BITS (TICK_COUNTER_BITS)
    ) u_step (
        .cur             (state_reg),
        .tick_cur        (tick_reg),
        .phase_ticks     (phase_reg),
        .preamble_pulses (preamble_reg),
        .item            (in_item_reg),
        .nxt             (state_next),
        .tick_nxt        (tick_next),
        .res             (res_next)
    );

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.step       <= ST_IDLE;
            state_reg.role       <= ROLE_ADDR_W;
            state_reg.bit_cnt    <= '0;
            state_reg.bytes_left <= '0;
            state_reg.shift_byte <= '0;
            state_reg.pulse_cnt  <= '0;
            state_reg.dev_addr   <= '0;
            state_reg.reg_addr   <= '0;
            state_reg.rd_mode    <= 1'b0;
            state_reg.nack       <= 1'b0;
            state_reg.scl        <= 1'b1;
            state_reg.sda        <= 1'b1;
            state_reg.sda_oe     <= 1'b1;
            tick_reg             <= '0;
        end
        else if (proc_en)
        begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_en)
        begin
            out_item_reg <= res_next;
        end
    end

`ifndef SYNTHESIS
    // a completed stop leaves the block idle
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.done_res |-> !out_item.busy_res)
        else $error("done pulse while still busy");

    // a received byte always belongs to a running transaction
    a_rx_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.read_byte_valid |-> out_item.busy_res)
        else $error("read byte outside a transaction");

    // a taken write byte starts a low clock phase
    a_take_scl_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.write_byte_taken |-> !out_item.scl_level)
        else $error("write byte taken with scl high");

    // sda stays released while waiting for write data
    a_wait_released: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.step == ST_WAIT_DATA |-> !state_reg.sda_oe)
        else $error("sda driven while waiting for data");

    // the sequencer moves only on a processed tick
    a_step_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !proc_en |=> $stable(state_reg.step))
        else $error("sequencer moved without a tick");
`endif

endmodule

// ===== sim/i2c_register_master_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_master_checker
// Watches the tick, result and configuration channels of the I2C register
// master, runs its own cycle-exact copy of the bus sequencer on every
// accepted tick and compares each accepted result field by field with the
// oldest prediction. Hands the mismatch count, the number of predictions
// still waiting and the predicted sequencer step to the testbench top.
// ----------------------------------------------------------------------------
module i2c_register_master_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  i2crm_pkg::in_t                in_item,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  i2crm_pkg::out_t               out_item,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  i2crm_pkg::cfg_index_t         cfg_index,
    input  logic [i2crm_pkg::PHASE_W-1:0] cfg_data,
    output int                            fail_count,
    output int                            pending,
    output i2crm_pkg::step_t              model_step
);
    import i2crm_pkg::*;

    // configuration copy
    logic [PHASE_W-1:0]           phase_reg;
    logic [PREAMBLE_W-1:0]        preamble_reg;

    // sequencer copy
    step_t                        step;
    role_t                        role;
    logic [2:0]                   bit_cnt;
    logic [COUNT_W-1:0]           bytes_left;
    logic [7:0]                   shift_byte;
    logic [TICK_COUNTER_BITS-1:0] phase_cnt;
    logic [PREAMBLE_W-1:0]        pulse_cnt;
    logic [6:0]                   dev_addr;
    logic [15:0]                  reg_addr;
    logic                         rd_mode;
    logic                         nack;
    logic                         scl;
    logic                         sda;
    logic                         sda_oe;

    // per-tick flags
    logic [7:0]                   rx_byte;
    logic                         rx_valid;
    logic                         rx_last;
    logic                         wr_taken;
    logic                         stop_done;

    out_t                         expected_ticks[$];
    out_t                         want;
    int                           results_seen;

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("%0t ns  result %0d: %s", $time, results_seen, msg);
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s is %0h, predicted %0h", name, got, exp_val));
    endtask

    task automatic compare_bit(input string name, input logic got, input logic exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s is %0b, predicted %0b", name, got, exp_val));
    endtask

    // move to a step, set its pin levels and load the hold count
    function automatic void enter_step(input step_t s);
        step = s;
        case (s)
            ST_PRE_HI, ST_STA_C, ST_TX_HI, ST_ACK_HI, ST_RX_HI, ST_MACK_HI, ST_STOP_C:
                scl = 1'b1;
            ST_PRE_LO, ST_STA_A, ST_TX_LO, ST_MACK_LO, ST_STOP_A:
                scl = 1'b0;
            ST_ACK_LO, ST_RX_LO:
            begin
                scl    = 1'b0;
                sda_oe = 1'b0;
            end
            ST_STA_B, ST_STOP_D:
            begin
                sda    = 1'b1;
                sda_oe = 1'b1;
            end
            ST_STA_D, ST_STOP_B:
            begin
                sda    = 1'b0;
                sda_oe = 1'b1;
            end
            ST_TX_SET:
            begin
                sda    = shift_byte[7];
                sda_oe = 1'b1;
            end
            ST_MACK_SET:
            begin
                sda    = (bytes_left == '0);
                sda_oe = 1'b1;
            end
            default: ;
        endcase
        phase_cnt = (phase_reg == '0) ? '0 : phase_reg - 1'b1;
    endfunction

    // wait for a write byte, take it on the tick it is offered
    function automatic void take_write_byte(input in_t t);
        step = ST_WAIT_DATA;
        if (t.write_byte_valid)
        begin
            wr_taken   = 1'b1;
            shift_byte = t.write_byte;
            bit_cnt    = '0;
            enter_step(ST_TX_LO);
        end
    endfunction

    // one tick of the sequencer: update the state, return the result
    function automatic out_t predict_tick(input in_t t);
        out_t r;
        int   n;
        rx_byte   = '0;
        rx_valid  = 1'b0;
        rx_last   = 1'b0;
        wr_taken  = 1'b0;
        stop_done = 1'b0;

        if (step == ST_IDLE)
        begin
            if (t.command_valid)
            begin
                n = int'(t.byte_count);
                if (n == 0)
                    n = 1;
                if (n > MAX_BURST)
                    n = MAX_BURST;
                rd_mode    = t.mode;
                dev_addr   = t.device_address;
                reg_addr   = t.register_address;
                bytes_left = n[COUNT_W-1:0];
                nack       = 1'b0;
                pulse_cnt  = '0;
                bit_cnt    = '0;
                role       = ROLE_ADDR_W;
                shift_byte = {t.device_address, 1'b0};
                enter_step(preamble_reg != '0 ? ST_PRE_HI : ST_STA_A);
            end
        end
        else if (step == ST_WAIT_DATA)
            take_write_byte(t);
        else if (phase_cnt != '0)
            phase_cnt = phase_cnt - 1'b1;
        else
        begin
            case (step)
                ST_PRE_HI:   enter_step(ST_PRE_LO);
                ST_PRE_LO:
                begin
                    pulse_cnt = pulse_cnt + 1'b1;
                    enter_step(pulse_cnt < preamble_reg ? ST_PRE_HI : ST_STA_A);
                end
                ST_STA_A:    enter_step(ST_STA_B);
                ST_STA_B:    enter_step(ST_STA_C);
                ST_STA_C:    enter_step(ST_STA_D);
                ST_STA_D:
                begin
                    bit_cnt = '0;
                    enter_step(ST_TX_LO);
                end
                ST_TX_LO:    enter_step(ST_TX_SET);
                ST_TX_SET:   enter_step(ST_TX_HI);
                ST_TX_HI:
                begin
                    shift_byte = {shift_byte[6:0], 1'b0};
                    bit_cnt    = bit_cnt + 1'b1;
                    enter_step(bit_cnt == '0 ? ST_ACK_LO : ST_TX_LO);
                end
                ST_ACK_LO:   enter_step(ST_ACK_HI);
                // ack slot: flag a high sample, then pick the next byte
                ST_ACK_HI:
                begin
                    if (t.sda_sample)
                        nack = 1'b1;
                    case (role)
                        ROLE_ADDR_W:
                        begin
                            role       = ROLE_REG_HI;
                            shift_byte = reg_addr[15:8];
                            bit_cnt    = '0;
                            enter_step(ST_TX_LO);
                        end
                        ROLE_REG_HI:
                        begin
                            role       = ROLE_REG_LO;
                            shift_byte = reg_addr[7:0];
                            bit_cnt    = '0;
                            enter_step(ST_TX_LO);
                        end
                        ROLE_REG_LO:
                        begin
                            if (rd_mode)
                            begin
                                role       = ROLE_ADDR_R;
                                shift_byte = {dev_addr, 1'b1};
                                enter_step(ST_STA_A);
                            end
                            else
                            begin
                                role = ROLE_DATA;
                                take_write_byte(t);
                            end
                        end
                        ROLE_DATA:
                        begin
                            if (bytes_left != '0)
                                bytes_left = bytes_left - 1'b1;
                            if (bytes_left == '0)
                                enter_step(ST_STOP_A);
                            else
                                take_write_byte(t);
                        end
                        ROLE_ADDR_R:
                        begin
                            role       = ROLE_RX;
                            shift_byte = '0;
                            bit_cnt    = '0;
                            enter_step(ST_RX_LO);
                        end
                        default: enter_step(ST_STOP_A);
                    endcase
                end
                ST_RX_LO:    enter_step(ST_RX_HI);
                // shift a data bit in, hand out the byte after the eighth
                ST_RX_HI:
                begin
                    shift_byte = {shift_byte[6:0], t.sda_sample};
                    bit_cnt    = bit_cnt + 1'b1;
                    if (bit_cnt == '0)
                    begin
                        if (bytes_left != '0)
                            bytes_left = bytes_left - 1'b1;
                        rx_valid = 1'b1;
                        rx_byte  = shift_byte;
                        rx_last  = (bytes_left == '0);
                        enter_step(ST_MACK_LO);
                    end
                    else
                        enter_step(ST_RX_LO);
                end
                ST_MACK_LO:  enter_step(ST_MACK_SET);
                ST_MACK_SET: enter_step(ST_MACK_HI);
                ST_MACK_HI:
                begin
                    if (bytes_left == '0)
                        enter_step(ST_STOP_A);
                    else
                    begin
                        shift_byte = '0;
                        enter_step(ST_RX_LO);
                    end
                end
                ST_STOP_A:   enter_step(ST_STOP_B);
                ST_STOP_B:   enter_step(ST_STOP_C);
                ST_STOP_C:   enter_step(ST_STOP_D);
                ST_STOP_D:
                begin
                    stop_done = 1'b1;
                    step      = ST_IDLE;
                    phase_cnt = '0;
                end
                default:
                begin
                    step      = ST_IDLE;
                    phase_cnt = '0;
                end
            endcase
        end

        r.scl_level        = scl;
        r.sda_level        = sda;
        r.sda_drive_enable = sda_oe;
        r.read_byte        = rx_byte;
        r.read_byte_valid  = rx_valid;
        r.read_last        = rx_last;
        r.write_byte_taken = wr_taken;
        r.nack_seen        = nack;
        r.busy_res         = (step != ST_IDLE);
        r.done_res         = stop_done;
        return r;
    endfunction

    // follow configuration writes, check results, predict accepted ticks
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    = PHASE_TICKS_RESET;
            preamble_reg = PREAMBLE_RESET;
            step         = ST_IDLE;
            role         = ROLE_ADDR_W;
            bit_cnt      = '0;
            bytes_left   = '0;
            shift_byte   = '0;
            phase_cnt    = '0;
            pulse_cnt    = '0;
            dev_addr     = '0;
            reg_addr     = '0;
            rd_mode      = 1'b0;
            nack         = 1'b0;
            scl          = 1'b1;
            sda          = 1'b1;
            sda_oe       = 1'b1;
            results_seen = 0;
            fail_count   = 0;
            expected_ticks.delete();
            pending      <= 0;
            model_step   <= ST_IDLE;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PHASE_TICKS:     phase_reg    = cfg_data;
                    CFG_PREAMBLE_PULSES: preamble_reg = cfg_data[PREAMBLE_W-1:0];
                    default: ;
                endcase
            end

            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_ticks.size() == 0)
                    report_mismatch("result transaction with no prediction waiting");
                else
                begin
                    want = expected_ticks.pop_front();
                    compare_bit("scl_level", out_item.scl_level, want.scl_level);
                    compare_bit("sda_level", out_item.sda_level, want.sda_level);
                    compare_bit("sda_drive_enable", out_item.sda_drive_enable,
                                want.sda_drive_enable);
                    compare_field("read_byte", out_item.read_byte, want.read_byte);
                    compare_bit("read_byte_valid", out_item.read_byte_valid,
                                want.read_byte_valid);
                    compare_bit("read_last", out_item.read_last, want.read_last);
                    compare_bit("write_byte_taken", out_item.write_byte_taken,
                                want.write_byte_taken);
                    compare_bit("nack_seen", out_item.nack_seen, want.nack_seen);
                    compare_bit("busy_res", out_item.busy_res, want.busy_res);
                    compare_bit("done_res", out_item.done_res, want.done_res);
                end
            end

            if (in_valid && !in_stall)
                expected_ticks.push_back(predict_tick(in_item));

            pending    <= expected_ticks.size();
            model_step <= step;
        end
    end

endmodule

// ===== sim/i2c_register_master_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_register_master_core_tb
// Drives the I2C register master with bus transfers tick by tick: directed
// corner transfers first, then random writes and reads under several
// timing and preamble settings, with random idling on both channels, a long
// result hold-off and a full drain. The checker beside the block predicts
// and compares every result; this top gives the verdict.
// ----------------------------------------------------------------------------
module i2c_register_master_core_tb;
    import i2crm_pkg::*;

    localparam int CYCLE_LIMIT  = 100_000;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_TICKS = 200;
    localparam int SETTLE_TICKS = 4;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    in_t                in_item;
    logic               out_valid;
    logic               out_stall;
    out_t               out_item;
    logic               cfg_valid;
    logic               cfg_ready;
    cfg_index_t         cfg_index;
    logic [PHASE_W-1:0] cfg_data;

    int                 fail_count;
    int                 pending;
    step_t              model_step;

    int                 send_idle_pct = 17;
    int                 recv_idle_pct = 49;
    int                 hold_requests = 0;
    int                 holds_done    = 0;
    int                 cycle_count   = 0;
    int                 random_ticks  = 0;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    i2c_register_master_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    i2c_register_master_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .model_step (model_step)
    );

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off when requested
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done++;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // random tick content; a command only where the sequencer is surely busy
    function automatic in_t line_tick(input int sda_pct, input int wr_pct,
                                      input logic allow_cmd);
        in_t t;
        t.command_valid    = allow_cmd && ($urandom_range(0, 9) == 0);
        t.mode             = 1'($urandom_range(0, 1));
        t.device_address   = 7'($urandom_range(0, 127));
        t.register_address = 16'($urandom_range(0, 65535));
        t.byte_count       = COUNT_W'($urandom_range(0, 511));
        t.write_byte       = 8'($urandom_range(0, 255));
        t.write_byte_valid = ($urandom_range(0, 99) < wr_pct);
        t.sda_sample       = ($urandom_range(0, 99) < sda_pct);
        return t;
    endfunction

    // one tick transaction, with an optional gap before it
    task automatic send_tick(input in_t t);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // start a bus transfer and feed ticks until the sequencer is idle again;
    // the predicted step seen here lags one tick behind
    task automatic run_transfer(input logic rd, input logic [6:0] dev,
                                input logic [15:0] reg_a, input logic [COUNT_W-1:0] count,
                                input int sda_pct, input int wr_pct,
                                input int hold_at, input int drain_at);
        in_t t;
        int  n;
        t                  = line_tick(sda_pct, wr_pct, 1'b0);
        t.command_valid    = 1'b1;
        t.mode             = rd;
        t.device_address   = dev;
        t.register_address = reg_a;
        t.byte_count       = count;
        send_tick(t);
        n = 0;
        do
        begin
            n++;
            if (n == hold_at)
                hold_requests <= hold_requests + 1;
            if (n == drain_at)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            send_tick(line_tick(sda_pct, wr_pct,
                                model_step != ST_IDLE && model_step != ST_STOP_D));
        end
        while (model_step != ST_IDLE);
        random_ticks += n + 1;
    endtask

    // stop offering ticks and let every result come back
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_config(input logic [PHASE_W-1:0] phase_val,
                                input logic [PREAMBLE_W-1:0] preamble_val);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_PHASE_TICKS;
        cfg_data  <= phase_val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_index <= CFG_PREAMBLE_PULSES;
        cfg_data  <= PHASE_W'(preamble_val);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // random transfers with idle ticks between them
    task automatic random_phase();
        logic [COUNT_W-1:0] count;
        int                 sda_pct;
        int                 wr_pct;
        int                 pick;
        random_ticks = 0;
        while (random_ticks < RANDOM_TICKS)
        begin
            repeat ($urandom_range(0, 3))
                send_tick(line_tick(50, 50, 1'b0));
            pick = $urandom_range(0, 19);
            if (pick == 0)
                count = '0;
            else if (pick == 1)
                count = COUNT_W'($urandom_range(9, 16));
            else
                count = COUNT_W'($urandom_range(1, 4));
            case ($urandom_range(0, 3))
                0:       sda_pct = 0;
                1:       sda_pct = 10;
                2:       sda_pct = 50;
                default: sda_pct = 100;
            endcase
            case ($urandom_range(0, 2))
                0:       wr_pct = 100;
                1:       wr_pct = 60;
                default: wr_pct = 15;
            endcase
            run_transfer(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                         16'($urandom_range(0, 65535)), count, sda_pct, wr_pct, 0, 0);
        end
        settle();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PHASE_TICKS;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed transfers at the reset settings
        // count zero runs as one byte, with a long result hold-off
        run_transfer(1'b0, 7'h00, 16'h0000, 9'd0, 0, 100, 40, 0);
        // every slot sampled high, with a full drain midway
        run_transfer(1'b1, 7'h7F, 16'hFFFF, 9'd1, 100, 100, 0, 60);
        settle();

        // zero phase ticks and no preamble
        write_config(10'd0, 5'd0);
        random_phase();

        // swapped idling, longest preamble
        send_idle_pct = 49;
        recv_idle_pct = 17;
        write_config(10'd1, 5'd31);
        random_phase();

        // no idling
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_config(PHASE_W'($urandom_range(1, 3)), PREAMBLE_W'($urandom_range(0, 8)));
        random_phase();

        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/i2crm_pkg.sv
rtl/i2crm_step.sv
rtl/i2c_register_master_core.sv
sim/i2c_register_master_checker.sv
sim/i2c_register_master_core_tb.sv
